[rtl/core/assert_macros.svh]
// Assertion macros shared by the transcoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define U16U8_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define U16U8_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/core/u16u8_pkg.sv]
// Types, constants and byte encoder shared by the transcoder modules.
package u16u8_pkg;

    localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
    localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;
    localparam logic [15:0] ONE_BYTE_MAX  = 16'h007F;
    localparam logic [15:0] TWO_BYTE_MAX  = 16'h07FF;

    localparam logic [7:0] LEAD2_MARK = 8'hC0;
    localparam logic [7:0] LEAD3_MARK = 8'hE0;
    localparam logic [7:0] LEAD4_MARK = 8'hF0;
    localparam logic [7:0] CONT_MARK  = 8'h80;
    localparam logic [7:0] CONT_MASK  = 8'h3F;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // Run length codes (bytes minus one)
    typedef enum logic [1:0] {
        LEN_ONE   = 2'd0,
        LEN_TWO   = 2'd1,
        LEN_THREE = 2'd2,
        LEN_FOUR  = 2'd3
    } run_len_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [20:0] code_point;
        run_len_t    len;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        cont_byte = CONT_MARK | ({2'b00, bits} & CONT_MASK);
    endfunction

    // Byte number idx of the UTF-8 encoding of cp
    function automatic logic [7:0] utf8_byte_at(input logic [20:0] cp,
                                                input run_len_t    len,
                                                input logic [1:0]  idx);
        logic [7:0] b;
        b = 8'h00;
        case (len)
            LEN_ONE:   b = {1'b0, cp[6:0]};
            LEN_TWO:   b = (idx == 2'd0) ? (LEAD2_MARK | {3'b000, cp[10:6]})
                                         : cont_byte(cp[5:0]);
            LEN_THREE:
            begin
                case (idx)
                    2'd0:    b = LEAD3_MARK | {4'b0000, cp[15:12]};
                    2'd1:    b = cont_byte(cp[11:6]);
                    default: b = cont_byte(cp[5:0]);
                endcase
            end
            LEN_FOUR:
            begin
                case (idx)
                    2'd0:    b = LEAD4_MARK | {5'b00000, cp[20:18]};
                    2'd1:    b = cont_byte(cp[17:12]);
                    2'd2:    b = cont_byte(cp[11:6]);
                    default: b = cont_byte(cp[5:0]);
                endcase
            end
            default:   b = 8'h00;
        endcase
        utf8_byte_at = b;
    endfunction

endpackage

[rtl/core/u16u8_front.sv]
// Front end: accepts code units, pairs surrogates, queues code points.
module u16u8_front
    import u16u8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    input  q_status_t q_status,
    output logic      push,
    output q_entry_t  push_entry
);

    logic       held_valid_reg, held_valid_next;
    logic [9:0] held_bits_reg, held_bits_next;
    logic       accept, is_low, is_high, is_plain, emit;
    logic [15:0] unit;

    assign unit     = in_item.code_unit;
    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        is_low   = unit inside {[LOW_SURR_MIN:LOW_SURR_MAX]};
        is_high  = unit inside {[HIGH_SURR_MIN:HIGH_SURR_MAX]};
        is_plain = !is_low && !is_high && (unit != 16'h0000);
        emit     = (is_low && held_valid_reg) || is_plain;

        push_entry.code_point = {5'b00000, unit};
        if (is_low)
            push_entry.code_point = SUPP_BASE + {1'b0, held_bits_reg, unit[9:0]};

        if (is_low)
            push_entry.len = LEN_FOUR;
        else if (unit <= ONE_BYTE_MAX)
            push_entry.len = LEN_ONE;
        else if (unit <= TWO_BYTE_MAX)
            push_entry.len = LEN_TWO;
        else
            push_entry.len = LEN_THREE;

        push = accept && emit;

        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        if (accept)
        begin
            // Anything but a non-final high surrogate drops the held high
            held_valid_next = is_high && !in_item.end_of_text;
            held_bits_next  = held_valid_next ? unit[9:0] : 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= 10'd0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

endmodule

[rtl/core/u16u8_queue.sv]
// Short queue of pending code points between front and back.
`include "assert_macros.svh"
module u16u8_queue
    import u16u8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  pop_entry,
    output q_status_t status
);

    q_entry_t         slots_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     count_reg;

    assign status.full  = (count_reg == QDEPTH[QAW:0]);
    assign status.empty = (count_reg == '0);
    assign pop_entry    = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `U16U8_ASSERT(a_no_overflow, push |-> !status.full, "push into full queue")
    `U16U8_ASSERT(a_no_underflow, pop |-> !status.empty, "pop from empty queue")
    `U16U8_ASSERT(a_count_range, count_reg <= QDEPTH[QAW:0], "queue count out of range")

endmodule

[rtl/core/u16u8_back.sv]
// Back end: serializes queued code points into UTF-8 bytes.
`include "assert_macros.svh"
module u16u8_back
    import u16u8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_status,
    input  q_entry_t  pop_entry,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic        busy_reg, busy_next;
    logic [20:0] cp_reg, cp_next;
    run_len_t    len_reg, len_next;
    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg, out_item_next;
    logic        advance, finishing;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        advance   = !out_valid_reg || out_ready;
        finishing = busy_reg && advance && (idx_reg == len_reg);

        busy_next      = busy_reg;
        cp_next        = cp_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        pop            = 1'b0;

        if (advance)
        begin
            out_valid_next = busy_reg;
            if (busy_reg)
            begin
                out_item_next.utf8_byte   = utf8_byte_at(cp_reg, len_reg, idx_reg);
                out_item_next.last_of_run = (idx_reg == len_reg);
                idx_next                  = idx_reg + 2'd1;
            end
        end

        // Load the next run when idle or as the current one ends
        if (!busy_reg || finishing)
        begin
            pop       = !q_status.empty;
            busy_next = !q_status.empty;
            if (!q_status.empty)
            begin
                cp_next  = pop_entry.code_point;
                len_next = pop_entry.len;
                idx_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg       <= cp_next;
        len_reg      <= len_next;
        out_item_reg <= out_item_next;
    end

    `U16U8_ASSERT(a_idx_in_run, busy_reg |-> (idx_reg <= len_reg), "byte index past run")
    `U16U8_ASSERT(a_pop_when_free, pop |-> (!busy_reg || finishing), "pop while run busy")
    `U16U8_ASSERT_NEXT(a_byte_from_run, (advance && busy_reg), out_valid_reg,
        "run byte not presented")

endmodule

[rtl/core/utf16_to_utf8_transcoder.sv]
// Top level of the UTF-16 to UTF-8 transcoder.
// Takes one UTF-16 code unit per item and emits the UTF-8 bytes for it, one byte
// per output item, with last_of_run marking the final byte of each unit's run.
// A high surrogate is held and combined with a following low surrogate into a
// four-byte supplementary code point; unpaired surrogates, zero units and a high
// surrogate on the end_of_text unit produce no bytes, and end_of_text always
// clears the held high. The front end accepts a unit in the cycle it arrives
// whenever the two-entry code point queue has room, so input items may follow
// each other back to back. The back end serializer emits one byte per cycle while
// out_ready allows it, so a unit yields 1 to 3 bytes for basic-plane units, 4
// for a surrogate pair and none for dropped units. Once the queue fills, input
// waits on in_ready until the serializer takes an entry. From input accept, a
// unit passes through the queue slot, the serializer's code point register and
// the output register before its first byte is valid.
module utf16_to_utf8_transcoder
    import u16u8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    // Front to queue
    logic      push;
    q_entry_t  push_entry;
    // Queue to back
    logic      pop;
    q_entry_t  pop_entry;
    q_status_t q_status;

    u16u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    u16u8_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    u16u8_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_entry (pop_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
